// ===== hdl/hsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types, constants and the CRC-8 step for the measurement frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hsfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [15:0] FULL_SCALE  = 16'd65535;
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;

  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2
  } hsfd_status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } hsfd_in_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic [15:0]        raw_temperature;
    logic [15:0]        raw_humidity;
    hsfd_status_t       status;
  } hsfd_out_t;

  typedef struct packed {
    logic         done;
    logic [15:0]  temp_word;
    logic [15:0]  hum_word;
    hsfd_status_t status;
  } hsfd_frame_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // floor(x / 65535) for x < 2^31: estimate by x >> 16, remainder stays below 2*65535
  function automatic logic [15:0] div_full_scale(input logic [30:0] x);
    logic [14:0] qe;
    logic [16:0] r;
    qe = x[30:16];
    r  = {1'b0, x[15:0]} + {2'b00, qe};
    return {1'b0, qe} + ((r >= {1'b0, FULL_SCALE}) ? 16'd1 : 16'd0);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/hsfd_frame_tracker.sv =====
// ----------------------------------------------------------------------------
// hsfd_frame_tracker
// Tracks byte position, assembles both words and checks each word's CRC-8.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfd_frame_tracker
  import hsfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire hsfd_in_t    in_data,
  output hsfd_frame_t      frame,
  output logic             last_pending
);

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic [15:0] hum_word_r, hum_word_nxt;
  logic        temp_good_r, temp_good_nxt;
  logic [2:0]  pos;
  logic        hum_good;

  assign last_pending = (pos_r == POS_H_CRC);

  always_comb begin
    pos           = in_data.frame_start ? POS_T_HI : pos_r;
    if (pos > POS_H_CRC) pos = POS_T_HI;
    pos_nxt       = pos + 3'd1;
    crc_nxt       = crc_r;
    temp_word_nxt = temp_word_r;
    hum_word_nxt  = hum_word_r;
    temp_good_nxt = temp_good_r;
    hum_good      = (crc_r == in_data.rx_byte);
    frame.done      = 1'b0;
    frame.temp_word = temp_word_r;
    frame.hum_word  = hum_word_r;
    frame.status    = STATUS_OK;
    case (pos)
      POS_T_HI: begin
        crc_nxt       = crc8_step(CRC_INIT, in_data.rx_byte);
        temp_word_nxt = {in_data.rx_byte, 8'h00};
      end
      POS_T_LO: begin
        crc_nxt       = crc8_step(crc_r, in_data.rx_byte);
        temp_word_nxt = {temp_word_r[15:8], in_data.rx_byte};
      end
      POS_T_CRC: begin
        temp_good_nxt = hum_good;
        crc_nxt       = CRC_INIT;
      end
      POS_H_HI: begin
        crc_nxt      = crc8_step(CRC_INIT, in_data.rx_byte);
        hum_word_nxt = {in_data.rx_byte, 8'h00};
      end
      POS_H_LO: begin
        crc_nxt      = crc8_step(crc_r, in_data.rx_byte);
        hum_word_nxt = {hum_word_r[15:8], in_data.rx_byte};
      end
      default: begin
        crc_nxt    = CRC_INIT;
        pos_nxt    = POS_T_HI;
        frame.done = 1'b1;
        if (!temp_good_r) frame.status = STATUS_TEMP_CRC;
        else if (!hum_good) frame.status = STATUS_HUM_CRC;
        else frame.status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_T_HI;
      crc_r       <= CRC_INIT;
      temp_word_r <= '0;
      hum_word_r  <= '0;
      temp_good_r <= 1'b0;
    end else if (accept) begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      temp_word_r <= temp_word_nxt;
      hum_word_r  <= hum_word_nxt;
      temp_good_r <= temp_good_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hsfd_scaler.sv =====
// ----------------------------------------------------------------------------
// hsfd_scaler
// Converts raw words to centi-degrees and centi-percent with an exact floor.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfd_scaler
  import hsfd_pkg::*;
(
  input  wire hsfd_frame_t        frame,
  output hsfd_out_t               result
);

  logic [30:0] temp_prod;
  logic [29:0] hum_prod;
  logic [15:0] temp_q;
  logic [15:0] hum_q;
  logic [15:0] temp_c;

  always_comb begin
    temp_prod = 31'(frame.temp_word) * 31'(TEMP_SPAN);
    hum_prod  = 30'(frame.hum_word) * 30'(HUM_SPAN);
    temp_q    = div_full_scale(temp_prod);
    hum_q     = div_full_scale({1'b0, hum_prod});
    temp_c    = temp_q - TEMP_OFFSET;

    result.raw_temperature = frame.temp_word;
    result.raw_humidity    = frame.hum_word;
    result.status          = frame.status;
    if (frame.status == STATUS_OK) begin
      result.temperature_centi = $signed(temp_c[14:0]);
      result.humidity_centi    = hum_q[13:0];
    end else begin
      result.temperature_centi = '0;
      result.humidity_centi    = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/humidity_sensor_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_core
// Decodes six-byte temperature/humidity frames with per-word CRC-8 checking.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one frame byte per word, in wire order;
//   in_data.frame_start forces the byte to be the first of a frame.
//   out_valid/out_ready/out_data carry one result per complete frame: scaled
//   temperature and humidity, both raw words and a CRC status.
//   Latency: the result is shown the cycle after the sixth byte is taken.
//   Throughput: one byte per cycle while in_ready is high; CRC step and constant
//   scaling sit between the byte handshake and the result register.
//   Stall: while a result waits, the first five bytes of the next frame are
//   still taken; a sixth byte waits until the held result is taken.
//   Reset: synchronous on rst_n low; position returns to the first byte,
//   the CRC to 0xFF and the result register empties.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_sensor_frame_decoder_core
  import hsfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire hsfd_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output hsfd_out_t      out_data
);

  hsfd_frame_t frame;
  hsfd_out_t   result;
  logic        last_pending;
  logic        accept;
  logic        out_valid_r;
  hsfd_out_t   out_data_r;

  assign in_ready  = !out_valid_r || out_ready || !last_pending;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  hsfd_frame_tracker u_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_data      (in_data),
    .frame        (frame),
    .last_pending (last_pending)
  );

  hsfd_scaler u_scaler (
    .frame  (frame),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && frame.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame.done) begin
      out_data_r <= result;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hsfd_checker.sv =====
// ----------------------------------------------------------------------------
// hsfd_checker
// Port-level assertions for the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfd_checker
  import hsfd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire hsfd_out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_new_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without accepted byte");

  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_OK |->
      out_data.temperature_centi == 15'sd0 && out_data.humidity_centi == 14'd0)
    else $error("scaled values not zero on CRC error");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.humidity_centi <= HUM_SPAN)
    else $error("humidity out of range");

endmodule

bind humidity_sensor_frame_decoder_core hsfd_checker u_hsfd_checker (.*);

`default_nettype wire
